@@ rtl/assert_macros.svh @@
// assertion macros used by the encoder top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rne_pkg.sv @@
// types, constants and the step table of the roman numeral encoder
package rne_pkg;

    localparam int VALUE_W  = 12;
    localparam int SYM_W    = 8;
    localparam int STEP_W   = 4;
    localparam int STEP_CNT = 13;

    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(3999);

    localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

    // one queued request after classification
    typedef struct packed {
        logic               err;
        logic [VALUE_W-1:0] value;
    } job_t;

    // queue fill status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    // one greedy step: weight, first letter, optional second letter
    typedef struct packed {
        logic [VALUE_W-1:0] weight;
        logic [SYM_W-1:0]   first;
        logic [SYM_W-1:0]   second;
    } step_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EMIT,
        BK_SECOND
    } back_state_t;

    // step table, largest weight first
    function automatic step_t step_at(input logic [STEP_W-1:0] idx);
        step_t s;
        s = '0;
        unique case (idx)
            4'd0:    s = '{VALUE_W'(1000), SYM_M, SYM_NONE};
            4'd1:    s = '{VALUE_W'(900),  SYM_C, SYM_M};
            4'd2:    s = '{VALUE_W'(500),  SYM_D, SYM_NONE};
            4'd3:    s = '{VALUE_W'(400),  SYM_C, SYM_D};
            4'd4:    s = '{VALUE_W'(100),  SYM_C, SYM_NONE};
            4'd5:    s = '{VALUE_W'(90),   SYM_X, SYM_C};
            4'd6:    s = '{VALUE_W'(50),   SYM_L, SYM_NONE};
            4'd7:    s = '{VALUE_W'(40),   SYM_X, SYM_L};
            4'd8:    s = '{VALUE_W'(10),   SYM_X, SYM_NONE};
            4'd9:    s = '{VALUE_W'(9),    SYM_I, SYM_X};
            4'd10:   s = '{VALUE_W'(5),    SYM_V, SYM_NONE};
            4'd11:   s = '{VALUE_W'(4),    SYM_I, SYM_V};
            default: s = '{VALUE_W'(1),    SYM_I, SYM_NONE};
        endcase
        return s;
    endfunction

endpackage

@@ rtl/rne_front.sv @@
// front end: takes requests and flags out-of-range values
module rne_front
    import rne_pkg::*;
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    input  fifo_status_t       q_stat,
    output logic               push,
    output job_t               job
);

    // hold off while the queue is full
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    // classify: zero or above the largest numeral is an error
    always_comb
    begin
        job.value = value;
        job.err   = (value == '0) || (value > VALUE_MAX);
    end

endmodule

@@ rtl/rne_fifo.sv @@
// short queue between the front end and the character sequencer
module rne_fifo
    import rne_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  job_t         push_job,
    input  logic         pop,
    output job_t         pop_job,
    output fifo_status_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_job      = mem_reg[rd_ptr_reg];

    // pointer and count update with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/rne_back.sv @@
// back end: greedy character sequencer with output register
module rne_back
    import rne_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  fifo_status_t     q_stat,
    input  job_t             job,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [SYM_W-1:0] symbol,
    output logic             last,
    output logic             error
);

    back_state_t        state_reg, state_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [SYM_W-1:0]   pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]   symbol_reg, symbol_next;
    logic               last_reg, last_next;
    logic               error_reg, error_next;

    logic               can_load;
    logic               load;
    logic [STEP_W-1:0]  sel;
    step_t              cur;
    logic [VALUE_W-1:0] rem_sub;

    // output register frees when empty or taken this cycle
    assign can_load = !out_valid_reg || !out_stall;

    // largest step that fits the remainder
    always_comb
    begin
        step_t probe;
        sel = STEP_W'(STEP_CNT - 1);
        for (int i = STEP_CNT - 1; i >= 0; i--)
        begin
            probe = step_at(STEP_W'(i));
            if (rem_reg >= probe.weight)
            begin
                sel = STEP_W'(i);
            end
        end
    end

    assign cur     = step_at(sel);
    assign rem_sub = rem_reg - cur.weight;

    // next state
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && !job.err)
                begin
                    state_next = BK_EMIT;
                    rem_next   = job.value;
                end
            end
            BK_EMIT:
            begin
                if (can_load)
                begin
                    rem_next = rem_sub;
                    if (cur.second != SYM_NONE)
                    begin
                        state_next = BK_SECOND;
                        pend_next  = cur.second;
                    end
                    else if (rem_sub == '0)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_SECOND:
            begin
                if (can_load)
                begin
                    state_next = (rem_reg == '0) ? BK_IDLE : BK_EMIT;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs: queue pop and the character to load
    always_comb
    begin
        pop         = 1'b0;
        load        = 1'b0;
        symbol_next = symbol_reg;
        last_next   = last_reg;
        error_next  = error_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    if (job.err)
                    begin
                        pop         = can_load;
                        load        = can_load;
                        symbol_next = SYM_NONE;
                        last_next   = 1'b1;
                        error_next  = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
            end
            BK_EMIT:
            begin
                load        = can_load;
                symbol_next = cur.first;
                last_next   = (cur.second == SYM_NONE) && (rem_sub == '0);
                error_next  = 1'b0;
            end
            BK_SECOND:
            begin
                load        = can_load;
                symbol_next = pend_reg;
                last_next   = (rem_reg == '0);
                error_next  = 1'b0;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    // output valid tracks loads and takes
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        pend_reg <= pend_next;
        if (load)
        begin
            symbol_reg <= symbol_next;
            last_reg   <= last_next;
            error_reg  <= error_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

@@ rtl/roman_numeral_encoder.sv @@
// Roman numeral encoder: one value in, its numeral out one character per request.
// The first character is loaded after the value passes the queue and is popped in the idle state.
// An out-of-range value gives its single error request, loaded as it is popped from the queue.
// The sequencer pops a value, then loads its characters one by one as the output register frees;
// values wait in the queue during a numeral.
// Reset (rst_n low, asynchronous) empties the queue, idles the sequencer, drops out_valid.
`include "assert_macros.svh"

module roman_numeral_encoder
    import rne_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SYM_W-1:0]   symbol,
    output logic               last,
    output logic               error
);

    fifo_status_t q_stat;
    logic         push;
    logic         pop;
    job_t         push_job;
    job_t         pop_job;
    logic         is_letter;

    // accept and classify
    rne_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .q_stat   (q_stat),
        .push     (push),
        .job      (push_job)
    );

    // decoupling queue
    rne_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    // character sequencer
    rne_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .job       (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .last      (last),
        .error     (error)
    );

    // symbol is one of the seven numeral letters
    assign is_letter = (symbol == SYM_I) || (symbol == SYM_V) || (symbol == SYM_X) ||
                       (symbol == SYM_L) || (symbol == SYM_C) || (symbol == SYM_D) ||
                       (symbol == SYM_M);

    // checks
    `ASSERT_NOW(a_err_form, out_valid && error, last && (symbol == SYM_NONE), "bad error request")
    `ASSERT_NOW(a_letter, out_valid && !error, is_letter, "bad letter")
    `ASSERT_NOW(a_q_sane, q_stat.full, !q_stat.empty, "queue both full and empty")
    `ASSERT_NEXT(a_push_lands, push, !q_stat.empty, "queue empty after push")

endmodule

@@ tb/roman_numeral_encoder_check.sv @@
// checker for the roman numeral encoder: predicts each numeral and compares character requests
module roman_numeral_encoder_check
    import rne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [SYM_W-1:0]   symbol,
    input  logic               last,
    input  logic               error,
    output int                 fail_count,
    output int                 chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // one expected character request
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             fin;
        logic             err;
    } roman_char_t;

    roman_char_t expected_chars[$];
    roman_char_t want;

    // greedy weights with their letters: {weight, first, second}
    function automatic logic [27:0] numeral_step(input int idx);
        case (idx)
            0:       return {12'd1000, SYM_M, SYM_NONE};
            1:       return {12'd900,  SYM_C, SYM_M};
            2:       return {12'd500,  SYM_D, SYM_NONE};
            3:       return {12'd400,  SYM_C, SYM_D};
            4:       return {12'd100,  SYM_C, SYM_NONE};
            5:       return {12'd90,   SYM_X, SYM_C};
            6:       return {12'd50,   SYM_L, SYM_NONE};
            7:       return {12'd40,   SYM_X, SYM_L};
            8:       return {12'd10,   SYM_X, SYM_NONE};
            9:       return {12'd9,    SYM_I, SYM_X};
            10:      return {12'd5,    SYM_V, SYM_NONE};
            11:      return {12'd4,    SYM_I, SYM_V};
            default: return {12'd1,    SYM_I, SYM_NONE};
        endcase
    endfunction

    // queue the characters of one numeral, or the single error request
    function automatic void queue_numeral(input logic [VALUE_W-1:0] v);
        logic [SYM_W-1:0] letters[16];
        logic [27:0]      st;
        roman_char_t      c;
        int               remain;
        int               idx;
        int               n;
        n = 0;
        idx = 0;
        remain = int'(v);
        if (v == '0 || v > VALUE_MAX)
        begin
            c.sym = SYM_NONE;
            c.fin = 1'b1;
            c.err = 1'b1;
            expected_chars.push_back(c);
            return;
        end
        while (remain != 0)
        begin
            st = numeral_step(idx);
            if (remain >= int'(st[27:16]))
            begin
                letters[n] = st[15:8];
                n++;
                if (st[7:0] != SYM_NONE)
                begin
                    letters[n] = st[7:0];
                    n++;
                end
                remain -= int'(st[27:16]);
            end
            else
                idx++;
        end
        for (int k = 0; k < n; k++)
        begin
            c.sym = letters[k];
            c.fin = (k == n - 1);
            c.err = 1'b0;
            expected_chars.push_back(c);
        end
    endfunction

    // watch both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_chars.delete();
            fail_count = 0;
            chars_pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                queue_numeral(value);
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected request, expected nothing, %s %h %b %b",
                             $realtime, "got symbol last error", symbol, last, error);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (symbol !== want.sym || last !== want.fin || error !== want.err)
                    begin
                        fail_count++;
                        $display("%0t: mismatch, expected symbol %h last %b error %b,",
                                 $realtime, want.sym, want.fin, want.err,
                                 " got symbol %h last %b error %b", symbol, last, error);
                    end
                end
            end
            chars_pending <= expected_chars.size();
        end
    end

endmodule

@@ tb/roman_numeral_encoder_test.sv @@
// testbench top for the roman numeral encoder: stimulus, receiver stalls, watchdog and verdict
module roman_numeral_encoder_test;
    import rne_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_VALUES = 185;
    localparam int DIRECTED_CNT  = 25;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [VALUE_W-1:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [SYM_W-1:0]   symbol;
    logic               last;
    logic               error;

    int fail_count;
    int chars_pending;
    int idle_cycles = 0;
    int stall_left = 0;
    int hold;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;

    // range ends, every subtractive pair, the longest numeral and top bit set
    int directed_values[DIRECTED_CNT] = '{0, 1, 3999, 4000, 4095, 3888, 4, 9, 40, 90, 400,
                                          900, 5, 50, 500, 1000, 2, 3, 14, 49, 99, 444,
                                          1994, 2048, 3000};

    roman_numeral_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .last      (last),
        .error     (error)
    );

    roman_numeral_encoder_check i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .symbol        (symbol),
        .last          (last),
        .error         (error),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stall after each character request, sometimes while idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if ($urandom_range(0, 19) == 0)
                    out_calm = !out_calm;
                hold = out_calm ? 0 : $urandom_range(0, 7);
                stall_left <= hold;
                out_stall <= (hold != 0);
            end
            else if (stall_left > 1)
                stall_left <= stall_left - 1;
            else if (stall_left == 1)
            begin
                stall_left <= 0;
                out_stall <= 1'b0;
            end
            else if (!out_calm && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(1, 7);
                out_stall <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no request taken on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("%0t: watchdog, no progress for %0d cycles", $realtime, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // offer one value after a random gap, hold it until taken
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop sending until every predicted character has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (chars_pending != 0);
    endtask

    // mostly in-range values, some small ones, some zero and out-of-range
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r <= 2)
            return VALUE_W'($urandom_range(4000, 4095));
        else if (r <= 6)
            return VALUE_W'($urandom_range(1, 50));
        else
            return VALUE_W'($urandom_range(1, 3999));
    endfunction

    // reset, directed values, random values, drain, verdict
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_values[i])
            send_value(VALUE_W'(directed_values[i]));
        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            if (i == RANDOM_VALUES / 2)
                wait_drained();
            if ($urandom_range(0, 19) == 0)
                in_calm = !in_calm;
            send_value(pick_value());
        end
        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
